FILE: rtl/fbfl_pkg.sv
// Package for the fixed block free-list allocator.
// Holds field widths, request and status codes, reset values and the
// command struct shared by the counter unit and the top level.
package fbfl_pkg;

  // Fixed field widths of the request and result channels.
  localparam int KIND_W   = 2;
  localparam int CIDX_W   = 8;
  localparam int REQ_W    = 16;
  localparam int ST_W     = 2;
  localparam int OFFS_W   = 24;
  localparam int CNT_W    = 9;
  localparam int BYTES_W  = 24;
  localparam int CB_W     = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_IN_USE = 1'b1;

  localparam logic [CB_W-1:0]  CHUNK_BYTES_RESET   = 16'd64;
  localparam logic [CNT_W-1:0] CHUNKS_IN_USE_RESET = 9'd256;

  localparam int DEF_MAX_CHUNKS = 256;

  // Saturation limits of the counters.
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_BIG = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_IDX = 2'd3;

  // Counter update operations.
  localparam logic [1:0] CNT_OP_ALLOC   = 2'd0;
  localparam logic [1:0] CNT_OP_FREE    = 2'd1;
  localparam logic [1:0] CNT_OP_REBUILD = 2'd2;

  typedef struct packed {
    logic       upd;
    logic [1:0] op;
  } cnt_cmd_t;

endpackage

FILE: rtl/fbfl_link_mem.sv
// Next-link memory of the free list: one write port and one read port.
// Synchronous read with the read data registered; depends on nothing else.
module fbfl_link_mem #(
  parameter int DEPTH  = 256,
  parameter int IDX_W  = 8,
  parameter int LINK_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [LINK_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [DEPTH];
  logic [LINK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fbfl_counters.sv
// Free, live and used-byte counters of the allocator with saturation.
// Uses fbfl_pkg for widths, operation codes and the command struct.
module fbfl_counters (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbfl_pkg::cnt_cmd_t          cmd,
  input  logic [fbfl_pkg::CNT_W-1:0]  pool_n,
  input  logic [fbfl_pkg::CB_W-1:0]   chunk_bytes,
  output logic [fbfl_pkg::CNT_W-1:0]  free_nxt,
  output logic [fbfl_pkg::CNT_W-1:0]  live_nxt,
  output logic [fbfl_pkg::BYTES_W-1:0] used_nxt
);
  import fbfl_pkg::*;

  logic [CNT_W-1:0]   free_r;
  logic [CNT_W-1:0]   live_r;
  logic [BYTES_W-1:0] used_r;
  logic [BYTES_W:0]   used_sum;
  logic [BYTES_W-1:0] cb_ext;

  assign cb_ext   = BYTES_W'(chunk_bytes);
  assign used_sum = {1'b0, used_r} + {1'b0, cb_ext};

  always_comb begin
    free_nxt = free_r;
    live_nxt = live_r;
    used_nxt = used_r;
    if (cmd.upd) begin
      unique case (cmd.op)
        CNT_OP_ALLOC: begin
          free_nxt = (free_r != '0) ? free_r - 1'b1 : '0;
          live_nxt = (live_r != CNT_MAX) ? live_r + 1'b1 : CNT_MAX;
          used_nxt = used_sum[BYTES_W] ? BYTES_MAX : used_sum[BYTES_W-1:0];
        end
        CNT_OP_FREE: begin
          free_nxt = (free_r != CNT_MAX) ? free_r + 1'b1 : CNT_MAX;
          live_nxt = (live_r != '0) ? live_r - 1'b1 : '0;
          used_nxt = (used_r > cb_ext) ? used_r - cb_ext : '0;
        end
        CNT_OP_REBUILD: begin
          free_nxt = pool_n;
          live_nxt = '0;
          used_nxt = '0;
        end
        default: begin
          free_nxt = free_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      live_r <= '0;
      used_r <= '0;
    end else begin
      free_r <= free_nxt;
      live_r <= live_nxt;
      used_r <= used_nxt;
    end
  end

endmodule

FILE: rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed block free-list allocator.
// Depends on fbfl_pkg, fbfl_link_mem and fbfl_counters.
//
// The block hands out equal-sized chunks of a pool, each named by its index.
// Requests arrive on the in_ channel (valid/stall): kind 0 allocates, kind 1
// frees in_chunk_index, kind 2 rebuilds the whole free list. Each request
// gives exactly one result on the out_ channel with a status, the granted
// index and its byte offset, and the free, live and used-byte totals after
// the request. The user writes configuration (chunk size, chunks in use) over
// the cfg_ port only while the block is idle; the block does not enforce it.
//
// One request is worked on at a time. A free, a rejected request or an
// unused kind shows its result in the cycle after acceptance. An allocate
// reads the link of the head on acceptance and completes in S_ALLOC, where
// the registered read data gives the next head. A rebuild writes one link
// entry per cycle for n = min(chunks_in_use, MAX_CHUNKS) entries.
//
// Reset empties the free list and clears the totals; the link memory itself
// is not cleared, since every entry is written before it can be read. The
// result sits in an output register. While the receiver stalls it holds the
// result, and the block takes the next request only once the register is
// being emptied, so back pressure reaches the request side.
module fixed_block_free_list_allocator #(
  parameter int MAX_CHUNKS = fbfl_pkg::DEF_MAX_CHUNKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fbfl_pkg::KIND_W-1:0]      in_kind,
  input  logic [fbfl_pkg::CIDX_W-1:0]      in_chunk_index,
  input  logic [fbfl_pkg::REQ_W-1:0]       in_request_bytes,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fbfl_pkg::ST_W-1:0]        out_status,
  output logic [fbfl_pkg::CIDX_W-1:0]      out_granted_index,
  output logic [fbfl_pkg::OFFS_W-1:0]      out_byte_offset,
  output logic [fbfl_pkg::CNT_W-1:0]       out_free_chunks,
  output logic [fbfl_pkg::CNT_W-1:0]       out_live_allocations,
  output logic [fbfl_pkg::BYTES_W-1:0]     out_used_bytes,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fbfl_pkg::*;

  // Chunk index width and link width; the link code MAX_CHUNKS means null.
  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LINK_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_CHUNKS);
  localparam int PROD_W = IDX_W + CB_W;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_ALLOC   = 2'd1;
  localparam logic [1:0] S_REBUILD = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   rbld_cnt_r, rbld_cnt_nxt;
  logic [CB_W-1:0]    chunk_bytes_r;
  logic [CNT_W-1:0]   chunks_in_use_r;
  logic [CNT_W-1:0]   pool_n;

  // Link memory access.
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [LINK_W-1:0]  mem_rdata;

  // Counter unit.
  cnt_cmd_t           cnt_cmd;
  logic [CNT_W-1:0]   free_nxt;
  logic [CNT_W-1:0]   live_nxt;
  logic [BYTES_W-1:0] used_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [ST_W-1:0]    res_status;
  logic [CIDX_W-1:0]  res_granted;
  logic [OFFS_W-1:0]  res_offset;
  logic [ST_W-1:0]    out_status_r;
  logic [CIDX_W-1:0]  out_granted_r;
  logic [OFFS_W-1:0]  out_offset_r;
  logic [CNT_W-1:0]   out_free_r;
  logic [CNT_W-1:0]   out_live_r;
  logic [BYTES_W-1:0] out_used_r;

  logic               in_accept;
  logic               head_null;
  logic               rbld_last;
  logic [PROD_W-1:0]  offset_prod;

  // Effective pool size, the smaller of chunks_in_use and the built capacity.
  assign pool_n = (32'(chunks_in_use_r) < MAX_CHUNKS) ? chunks_in_use_r
                                                      : CNT_W'(MAX_CHUNKS);

  // New requests are taken only when idle and the output register is free
  // or is being taken by the receiver in this cycle.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign head_null = (head_r >= LINK_NULL);
  assign rbld_last = (rbld_cnt_r == pool_n - 1'b1);

  // The granted chunk is still the head while the allocate completes.
  assign offset_prod = PROD_W'(head_r[IDX_W-1:0]) * PROD_W'(chunk_bytes_r);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    rbld_cnt_nxt = rbld_cnt_r;
    mem_we       = 1'b0;
    mem_waddr    = IDX_W'(in_chunk_index);
    mem_wdata    = head_r;
    mem_re       = 1'b0;
    cnt_cmd      = '{upd: 1'b0, op: CNT_OP_ALLOC};
    out_load     = 1'b0;
    res_status   = ST_OK;
    res_granted  = '0;
    res_offset   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            KIND_ALLOC: begin
              if (REQ_W'(in_request_bytes) > chunk_bytes_r) begin
                out_load   = 1'b1;
                res_status = ST_TOO_BIG;
              end else if (head_null) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                // Fetch the link of the head; the pop finishes next cycle.
                mem_re    = 1'b1;
                state_nxt = S_ALLOC;
              end
            end
            KIND_FREE: begin
              out_load = 1'b1;
              if (CNT_W'(in_chunk_index) >= pool_n) begin
                res_status = ST_BAD_IDX;
              end else begin
                mem_we   = 1'b1;
                head_nxt = LINK_W'(in_chunk_index);
                cnt_cmd  = '{upd: 1'b1, op: CNT_OP_FREE};
              end
            end
            KIND_REBUILD: begin
              if (pool_n == '0) begin
                out_load = 1'b1;
                head_nxt = LINK_NULL;
                cnt_cmd  = '{upd: 1'b1, op: CNT_OP_REBUILD};
              end else begin
                rbld_cnt_nxt = '0;
                state_nxt    = S_REBUILD;
              end
            end
            default: begin
              // The unused kind reports the current totals.
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        out_load    = 1'b1;
        res_granted = CIDX_W'(head_r[IDX_W-1:0]);
        res_offset  = OFFS_W'(offset_prod);
        head_nxt    = mem_rdata;
        cnt_cmd     = '{upd: 1'b1, op: CNT_OP_ALLOC};
        state_nxt   = S_IDLE;
      end
      S_REBUILD: begin
        // Chunk i links to chunk i-1, and chunk 0 ends the list.
        mem_we       = 1'b1;
        mem_waddr    = IDX_W'(rbld_cnt_r);
        mem_wdata    = (rbld_cnt_r == '0) ? LINK_NULL : LINK_W'(rbld_cnt_r - 1'b1);
        rbld_cnt_nxt = rbld_cnt_r + 1'b1;
        if (rbld_last) begin
          head_nxt  = LINK_W'(rbld_cnt_r);
          out_load  = 1'b1;
          cnt_cmd   = '{upd: 1'b1, op: CNT_OP_REBUILD};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  fbfl_link_mem #(
    .DEPTH  (MAX_CHUNKS),
    .IDX_W  (IDX_W),
    .LINK_W (LINK_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  fbfl_counters u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cnt_cmd),
    .pool_n      (pool_n),
    .chunk_bytes (chunk_bytes_r),
    .free_nxt    (free_nxt),
    .live_nxt    (live_nxt),
    .used_nxt    (used_nxt)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      head_r          <= LINK_NULL;
      rbld_cnt_r      <= '0;
      out_valid_r     <= 1'b0;
      chunk_bytes_r   <= CHUNK_BYTES_RESET;
      chunks_in_use_r <= CHUNKS_IN_USE_RESET;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      rbld_cnt_r  <= rbld_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CHUNK_BYTES:   chunk_bytes_r   <= CB_W'(cfg_data);
          REG_CHUNKS_IN_USE: chunks_in_use_r <= CNT_W'(cfg_data);
          default:           chunk_bytes_r   <= chunk_bytes_r;
        endcase
      end
    end
  end

  // Result payload; it only changes when a new result is loaded.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_offset_r  <= res_offset;
      out_free_r    <= free_nxt;
      out_live_r    <= live_nxt;
      out_used_r    <= used_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_granted_index    = out_granted_r;
  assign out_byte_offset      = out_offset_r;
  assign out_free_chunks      = out_free_r;
  assign out_live_allocations = out_live_r;
  assign out_used_bytes       = out_used_r;

  // A new result must never overwrite one the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // An allocate only completes from a non-empty list.
  a_alloc_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> !head_null)
    else $error("allocate completing with a null head");

  // The link memory is never read and written in the same cycle.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("link memory read and write overlap");

  // At the end of a rebuild the head is the highest chunk written.
  a_rebuild_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REBUILD && rbld_last) |=> (head_r == LINK_W'($past(rbld_cnt_r))))
    else $error("rebuild left a wrong head");

endmodule

FILE: tb/sv/fbfl_pool_sb_pkg.sv
// Scoreboard for the fixed block free-list allocator testbench.
// It mirrors the free list, counters and chunk settings to forecast every result.
// Depends on fbfl_pkg for field widths, register indexes and request and status codes.
package fbfl_pool_sb_pkg;
  import fbfl_pkg::*;

  localparam int unsigned POOL_CAP = DEF_MAX_CHUNKS;
  localparam logic [CNT_W-1:0] NO_LINK = 9'd256;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [CIDX_W-1:0]  granted;
    logic [OFFS_W-1:0]  offset;
    logic [CNT_W-1:0]   free_chunks;
    logic [CNT_W-1:0]   live_chunks;
    logic [BYTES_W-1:0] used_bytes;
  } pool_result_t;

  class pool_scoreboard;
    logic [CNT_W-1:0]   next_free [POOL_CAP];
    logic [CNT_W-1:0]   head;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   live_count;
    logic [BYTES_W-1:0] bytes_used;
    logic [CB_W-1:0]    chunk_size;
    logic [CNT_W-1:0]   chunk_limit;
    pool_result_t       awaited_results[$];
    logic [CIDX_W-1:0]  handed_out[$];
    int unsigned        errors;

    function new();
      head        = NO_LINK;
      free_count  = '0;
      live_count  = '0;
      bytes_used  = '0;
      chunk_size  = CHUNK_BYTES_RESET;
      chunk_limit = CHUNKS_IN_USE_RESET;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHUNK_BYTES) begin
        chunk_size = data[CB_W-1:0];
      end else begin
        chunk_limit = data[CNT_W-1:0];
      end
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function logic [CNT_W-1:0] drop(logic [CNT_W-1:0] v);
      return (v == '0) ? v : v - 1'b1;
    endfunction

    // Applies one accepted request to the mirrored pool and queues the result it owes.
    function void log_request(logic [KIND_W-1:0] kind, logic [CIDX_W-1:0] idx,
                              logic [REQ_W-1:0] req);
      pool_result_t     r;
      int unsigned      n;
      logic [BYTES_W:0] sum;
      r = '0;
      n = (chunk_limit < POOL_CAP) ? chunk_limit : POOL_CAP;
      if (kind == KIND_ALLOC) begin
        if (req > chunk_size) begin
          r.status = ST_TOO_BIG;
        end else if (head >= NO_LINK) begin
          r.status = ST_EMPTY;
        end else begin
          r.status   = ST_OK;
          r.granted  = head[CIDX_W-1:0];
          r.offset   = r.granted * chunk_size;
          head       = next_free[r.granted];
          free_count = drop(free_count);
          live_count = bump(live_count);
          sum        = bytes_used + chunk_size;
          bytes_used = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
          handed_out.push_back(r.granted);
        end
      end else if (kind == KIND_FREE) begin
        if (idx >= n) begin
          r.status = ST_BAD_IDX;
        end else begin
          next_free[idx] = head;
          head           = {1'b0, idx};
          free_count     = bump(free_count);
          live_count     = drop(live_count);
          bytes_used     = (bytes_used > chunk_size) ? bytes_used - chunk_size : '0;
        end
      end else if (kind == KIND_REBUILD) begin
        head = NO_LINK;
        for (int i = 0; i < n; i++) begin
          next_free[i] = head;
          head         = i[CNT_W-1:0];
        end
        free_count = n[CNT_W-1:0];
        live_count = '0;
        bytes_used = '0;
        handed_out.delete();
      end
      r.free_chunks = free_count;
      r.live_chunks = live_count;
      r.used_bytes  = bytes_used;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [OFFS_W-1:0] want, logic [OFFS_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result with no request outstanding, status %0d", $time, got.status);
        end
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("granted_index", want.granted, got.granted);
      compare_field("byte_offset", want.offset, got.offset);
      compare_field("free_chunks", want.free_chunks, got.free_chunks);
      compare_field("live_allocations", want.live_chunks, got.live_chunks);
      compare_field("used_bytes", want.used_bytes, got.used_bytes);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Hands back a chunk believed to be allocated, or -1 when none is known.
    function int pick_live_chunk();
      int pos;
      int chunk;
      if (handed_out.size() == 0) begin
        return -1;
      end
      pos   = $urandom_range(0, handed_out.size() - 1);
      chunk = handed_out[pos];
      handed_out.delete(pos);
      return chunk;
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_fixed_block_free_list_allocator.sv
// Testbench top for the fixed block free-list allocator.
// Drives directed and random requests, idles both channels, checks every result.
// Depends on fbfl_pkg, fbfl_pool_sb_pkg and the allocator RTL.
module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;
  import fbfl_pool_sb_pkg::*;

  // The block ignores the fourth kind code; the package gives it no name.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 30;
  localparam int MAX_GAP       = 8;
  localparam int SETTLE_CYCLES = 8;
  // The closing wait is longer than a full rebuild of the largest pool.
  localparam int END_CYCLES    = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 215;
  localparam int SAT_FREES     = 260;
  localparam int SAT_ALLOCS    = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind;
  logic [CIDX_W-1:0]     in_chunk_index;
  logic [REQ_W-1:0]      in_request_bytes;
  logic                  out_valid;
  logic                  out_stall;
  logic [ST_W-1:0]       out_status;
  logic [CIDX_W-1:0]     out_granted_index;
  logic [OFFS_W-1:0]     out_byte_offset;
  logic [CNT_W-1:0]      out_free_chunks;
  logic [CNT_W-1:0]      out_live_allocations;
  logic [BYTES_W-1:0]    out_used_bytes;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pool_scoreboard pool_sb = new();

  // While steady_flow is set neither side idles; hold_off asks the receiver for one
  // long stall so that back pressure reaches the request side.
  bit steady_flow = 1'b0;
  bit hold_off    = 1'b0;

  fixed_block_free_list_allocator u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_chunk_index       (in_chunk_index),
    .in_request_bytes     (in_request_bytes),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_granted_index    (out_granted_index),
    .out_byte_offset      (out_byte_offset),
    .out_free_chunks      (out_free_chunks),
    .out_live_allocations (out_live_allocations),
    .out_used_bytes       (out_used_bytes),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  // Both channels are sampled at the edge, before any of this edge's updates land,
  // so a handshake seen here is exactly the one the block saw.
  always @(posedge clk) begin : watch
    pool_result_t seen;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen = {out_status, out_granted_index, out_byte_offset, out_free_chunks,
                out_live_allocations, out_used_bytes};
        pool_sb.check_result(seen);
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pool_sb.log_request(in_kind, in_chunk_index, in_request_bytes);
      end
    end
  end

  // Result side: random stalls, none while steady_flow is set, and one long
  // hold-off on request that is counted here in cycles.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offers one request and returns at the edge that accepted it. Valid stays high,
  // so the caller either drives the next request or drops valid in this same step.
  // A random gap may follow, which drops valid itself.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [CIDX_W-1:0] idx,
                       input logic [REQ_W-1:0] req);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_chunk_index   <= idx;
    in_request_bytes <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every request has its result, plus a settling
  // wait so that the block is surely idle. The request accepted at the
  // current edge may not be logged yet, so the count is read from the next
  // edge on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The extra edge keeps the enable from being lowered and raised in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    pool_sb.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned chunk_size, input int unsigned chunks);
    settle();
    write_reg(REG_CHUNK_BYTES, chunk_size[CFG_DATA_W-1:0]);
    write_reg(REG_CHUNKS_IN_USE, chunks[CFG_DATA_W-1:0]);
  endtask

  // Mostly well-formed traffic: allocations that fit and frees of chunks that
  // are handed out. The rest is rare rebuilds and raw noise, which brings bad
  // indexes, oversize requests, double frees and the unused kind.
  task automatic random_item(input int alloc_pct);
    int roll;
    int live;
    roll = $urandom_range(0, 99);
    live = -1;
    if (roll < 3) begin
      issue(KIND_REBUILD, CIDX_W'($urandom_range(0, 255)), REQ_W'($urandom_range(0, 65535)));
    end else if (roll < 88) begin
      if ($urandom_range(0, 99) >= alloc_pct) begin
        live = pool_sb.pick_live_chunk();
      end
      if (live < 0) begin
        issue(KIND_ALLOC, CIDX_W'($urandom_range(0, 255)),
              ($urandom_range(0, 9) == 0) ? pool_sb.chunk_size
                                          : REQ_W'($urandom_range(0, pool_sb.chunk_size)));
      end else begin
        issue(KIND_FREE, live[CIDX_W-1:0], REQ_W'($urandom_range(0, 65535)));
      end
    end else begin
      issue(KIND_W'($urandom_range(0, 3)), CIDX_W'($urandom_range(0, 255)),
            REQ_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int unsigned cb;
    int unsigned chunks;
    int          alloc_pct;

    in_valid         <= 1'b0;
    in_kind          <= KIND_ALLOC;
    in_chunk_index   <= '0;
    in_request_bytes <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_CHUNK_BYTES;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset settings of 64-byte chunks and 256 chunks.
    // Before any rebuild the list is empty; a free still pushes its chunk while
    // the live count stays at its floor of zero.
    issue(KIND_ALLOC, 8'd0, 16'd0);
    issue(KIND_FREE, 8'd0, 16'd0);
    issue(KIND_ALLOC, 8'd0, 16'd64);
    issue(KIND_REBUILD, 8'd0, 16'd0);
    // A request of exactly the chunk size fits, one byte more does not.
    issue(KIND_ALLOC, 8'd0, 16'd64);
    issue(KIND_ALLOC, 8'd0, 16'd65);
    issue(KIND_ALLOC, 8'hFF, 16'hFFFF);
    // A double free is not caught, so the same chunk comes back twice.
    issue(KIND_FREE, 8'hFF, 16'd0);
    issue(KIND_FREE, 8'hFF, 16'hFFFF);
    issue(KIND_UNUSED, 8'hFF, 16'hFFFF);
    issue(KIND_ALLOC, 8'd0, 16'd0);
    issue(KIND_ALLOC, 8'd0, 16'd0);

    // Smallest pool and chunk: indexes from one up are bad, and an oversize
    // request on an empty pool reports oversize first.
    configure(8, 1);
    issue(KIND_REBUILD, 8'hFF, 16'd0);
    issue(KIND_FREE, 8'd1, 16'd0);
    issue(KIND_FREE, 8'hFF, 16'd0);
    issue(KIND_ALLOC, 8'd0, 16'd8);
    issue(KIND_ALLOC, 8'd0, 16'd8);
    issue(KIND_ALLOC, 8'd0, 16'd9);

    // Largest chunk: the top chunk has the largest byte offset.
    configure(65535, 256);
    issue(KIND_REBUILD, 8'd0, 16'd0);
    issue(KIND_ALLOC, 8'd0, 16'hFFFF);
    issue(KIND_FREE, 8'hAA, 16'h5555);
    issue(KIND_UNUSED, 8'd0, 16'd0);

    // Saturation run: frees on top of a full list drive the free count to its
    // ceiling, then allocations of the largest chunk drive used bytes to theirs.
    issue(KIND_REBUILD, 8'd0, 16'd0);
    repeat (SAT_FREES) issue(KIND_FREE, CIDX_W'($urandom_range(0, 255)),
                             REQ_W'($urandom_range(0, 65535)));
    repeat (SAT_ALLOCS) issue(KIND_ALLOC, CIDX_W'($urandom_range(0, 255)),
                              REQ_W'($urandom_range(0, 65535)));

    // Random phases, each with its own settings and mix.
    for (int p = 0; p < 6; p++) begin
      alloc_pct = 50;
      case (p)
        0: begin
          cb     = 8;
          chunks = 1;
        end
        1: begin
          cb        = 8;
          chunks    = 256;
          alloc_pct = 55;
        end
        2: begin
          cb     = 65535;
          chunks = 2;
        end
        3: begin
          cb        = $urandom_range(8, 65535);
          chunks    = $urandom_range(1, 256);
          alloc_pct = 45;
        end
        4: begin
          cb        = $urandom_range(8, 300);
          chunks    = $urandom_range(1, 8);
          alloc_pct = 60;
        end
        default: begin
          cb     = 64;
          chunks = 256;
        end
      endcase
      configure(cb, chunks);
      // Phase 1 runs with no idling on either side; phase 2 opens with the long
      // receiver hold-off while requests keep coming.
      steady_flow = (p == 1);
      hold_off    = (p == 2);
      // Now and then the old list is kept across a change of pool size.
      if (p != 3 || $urandom_range(0, 1) == 0) begin
        issue(KIND_REBUILD, CIDX_W'($urandom_range(0, 255)), REQ_W'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through the last phase the sender waits for every result.
        if (p == 5 && k == PHASE_ITEMS / 2) begin
          settle();
        end
        random_item(alloc_pct);
      end
      steady_flow = 1'b0;
    end

    in_valid <= 1'b0;
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (pool_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
